@@ rtl/gcsw_pkg.sv @@
// Shared constants and types of the gain / clip / sine waveshaper.
// No dependencies; the top level uses it.

package gcsw_pkg;

    // Configuration register indexes, as written on the config port.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_LINEAR  = 2'd0,
        CFG_CLIP_LEVEL   = 2'd1,
        CFG_SHAPE_ENABLE = 2'd2
    } t_cfg_idx;

    // Register widths and reset values.
    localparam int GAIN_W = 18;          // unsigned Q2.16
    localparam int CLIP_W = 17;          // unsigned Q1.16
    localparam int CFG_W  = 18;          // widest register
    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 17'd65536;

    // Gain and clip level carry 16 fraction bits; round half up.
    localparam int GAIN_FRAC = 16;
    localparam longint unsigned ROUND_HALF = 64'd32768;

    // Sine phase: 23 fraction bits per quadrant, two quadrant bits.
    localparam int PH_BITS = 23;
    localparam int PH_W    = PH_BITS + 3;    // folded phase work width
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

endpackage

@@ rtl/gcsw_in_if.sv @@
// Input sample channel of the waveshaper: valid / ready plus payload.
// No dependencies.

interface gcsw_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_block;

    modport source (output valid, output sample_in, output end_of_block, input ready);
    modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

@@ rtl/gcsw_out_if.sv @@
// Output sample channel of the waveshaper: valid / ready plus payload.
// No dependencies.

interface gcsw_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS+1:0]   sample_out;
    logic                            end_of_block_out;

    modport source (output valid, output sample_out, output end_of_block_out, input ready);
    modport sink   (input valid, input sample_out, input end_of_block_out, output ready);
endinterface

@@ rtl/gain_clip_sine_waveshaper.sv @@
// Gain, upper clip and optional sine soft shaping, five register stages: gain multiply,
// clip/saturate, phase fold and table read, interpolation multiply, add and sign.
// Throughput: one sample per cycle; a stall at the output freezes every stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Depends on gcsw_pkg, gcsw_in_if and gcsw_out_if.

module gain_clip_sine_waveshaper #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gcsw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcsw_pkg::CFG_W-1:0]  i_cfg_data,
    gcsw_in_if.sink                     i_smp,
    gcsw_out_if.source                  o_smp
);

    localparam int FRAC  = SAMPLE_BITS - 1;
    localparam int OUTW  = SAMPLE_BITS + 2;
    localparam int PW    = SAMPLE_BITS + gcsw_pkg::GAIN_W + 1;   // product width
    localparam int YW    = SAMPLE_BITS + 3;                      // rounded product
    localparam int CXW   = gcsw_pkg::CLIP_W + FRAC + 1;
    localparam int CW    = CXW - gcsw_pkg::GAIN_FRAC;            // clip in Q.F
    localparam int TAB_N = 1 << SINE_TABLE_BITS;
    localparam int TABW  = SINE_TABLE_BITS + 1;                  // table index
    localparam int KF    = gcsw_pkg::PH_BITS - SINE_TABLE_BITS;  // interp. bits
    localparam int SHL   = gcsw_pkg::PH_BITS - FRAC;
    localparam int PRW   = SAMPLE_BITS + KF;
    localparam logic signed [YW-1:0] OMAX = YW'((64'sd1 <<< (OUTW - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] OMIN = YW'(-(64'sd1 <<< (OUTW - 1)));
    localparam logic [23:0] QUARTER = 24'(64'd1 << gcsw_pkg::PH_BITS);
    localparam logic [PRW-1:0] HALF_LSB = PRW'(64'd1 << (KF - 1));

    typedef logic [SAMPLE_BITS-1:0] t_tab [TAB_N+1];

    // Quarter-wave table: round(sin(pi/2*i/N) * 2^F) from a Taylor series.
    function automatic t_tab f_sine_tab();
        t_tab        tab;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int i = 0; i <= TAB_N; i++) begin
            a    = (gcsw_pkg::PI_HALF_Q30 * 64'(i)) >> SINE_TABLE_BITS;
            a2   = (a * a) >> 30;
            term = a;
            sum  = $signed(a);
            term = ((term * a2) >> 30) / 64'd6;   sum = sum - $signed(term);
            term = ((term * a2) >> 30) / 64'd20;  sum = sum + $signed(term);
            term = ((term * a2) >> 30) / 64'd42;  sum = sum - $signed(term);
            term = ((term * a2) >> 30) / 64'd72;  sum = sum + $signed(term);
            term = ((term * a2) >> 30) / 64'd110; sum = sum - $signed(term);
            term = ((term * a2) >> 30) / 64'd156; sum = sum + $signed(term);
            term = ((term * a2) >> 30) / 64'd210; sum = sum - $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            tab[i] = SAMPLE_BITS'((64'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = f_sine_tab();

    // ---------------------------------------------------------------- config
    logic [gcsw_pkg::GAIN_W-1:0] r_gain_linear;
    logic [gcsw_pkg::CLIP_W-1:0] r_clip_level;
    logic                        r_shape_enable;

    // Load a register on a write; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_linear  <= gcsw_pkg::GAIN_RESET;
            r_clip_level   <= gcsw_pkg::CLIP_RESET;
            r_shape_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (gcsw_pkg::t_cfg_idx'(i_cfg_idx))
                gcsw_pkg::CFG_GAIN_LINEAR:  r_gain_linear  <= i_cfg_data[gcsw_pkg::GAIN_W-1:0];
                gcsw_pkg::CFG_CLIP_LEVEL:   r_clip_level   <= i_cfg_data[gcsw_pkg::CLIP_W-1:0];
                gcsw_pkg::CFG_SHAPE_ENABLE: r_shape_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    logic [5:1] r_v;
    logic [5:1] r_e;
    logic       w_en;

    // Advance all stages unless the output holds a result not yet taken.
    assign w_en        = !r_v[5] || o_smp.ready;
    assign i_smp.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[4:1], i_smp.valid};
        end
    end

    // Carry the end-of-block marker alongside the data.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e <= {r_e[4:1], i_smp.end_of_block};
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] r_p1;

    // Multiply by the gain and add the rounding half.
    assign w_p = $signed(i_smp.sample_in) * $signed({1'b0, r_gain_linear});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1 <= w_p + $signed(PW'(gcsw_pkg::ROUND_HALF));
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [PW-1:0]   w_psh;
    logic signed [YW-1:0]   w_y;
    logic [CXW-1:0]         w_cx;
    logic [CW-1:0]          w_c;
    logic signed [YW-1:0]   w_cs;
    logic signed [YW-1:0]   w_ycl;
    logic signed [YW-1:0]   w_ysat;
    logic signed [OUTW-1:0] r_y2;

    // Floor the product, clip from above only, saturate to the output range.
    assign w_psh = r_p1 >>> gcsw_pkg::GAIN_FRAC;
    assign w_y   = $signed(w_psh[YW-1:0]);
    assign w_cx  = (CXW'(r_clip_level) << FRAC) + CXW'(gcsw_pkg::ROUND_HALF);
    assign w_c   = w_cx[CXW-1:gcsw_pkg::GAIN_FRAC];
    assign w_cs  = $signed(YW'(w_c));

    always_comb begin
        w_ycl  = (w_y > w_cs) ? w_cs : w_y;
        w_ysat = w_ycl;
        if (w_ycl > OMAX) begin
            w_ysat = OMAX;
        end else if (w_ycl < OMIN) begin
            w_ysat = OMIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y2 <= $signed(w_ysat[OUTW-1:0]);
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [gcsw_pkg::PH_W-1:0] w_yx;
    logic signed [gcsw_pkg::PH_W-1:0] w_ph;
    logic [1:0]              w_q;
    logic [23:0]             w_f;
    logic [23:0]             w_u;
    logic [TABW-1:0]         w_idx;
    logic [TABW-1:0]         w_idx_hi;
    logic [SAMPLE_BITS-1:0]  r_lo3;
    logic [SAMPLE_BITS-1:0]  r_hi3;
    logic [KF-1:0]           r_fr3;
    logic                    r_neg3;
    logic signed [OUTW-1:0]  r_y3;

    // Fold the phase into the first quadrant and read two table neighbors.
    assign w_yx     = gcsw_pkg::PH_W'(r_y2);
    assign w_ph     = w_yx <<< SHL;
    assign w_q      = w_ph[gcsw_pkg::PH_BITS+1:gcsw_pkg::PH_BITS];
    assign w_f      = {1'b0, w_ph[gcsw_pkg::PH_BITS-1:0]};
    assign w_u      = w_q[0] ? (QUARTER - w_f) : w_f;
    assign w_idx    = w_u[23:KF];
    assign w_idx_hi = (w_idx == TABW'(TAB_N)) ? w_idx : (w_idx + TABW'(1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo3  <= SINE_TAB[w_idx];
            r_hi3  <= SINE_TAB[w_idx_hi];
            r_fr3  <= w_u[KF-1:0];
            r_neg3 <= w_q[1];
            r_y3   <= r_y2;
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [SAMPLE_BITS-1:0]  w_hi;
    logic [SAMPLE_BITS-1:0]  w_diff;
    logic [PRW-1:0]          r_prod4;
    logic [SAMPLE_BITS-1:0]  r_lo4;
    logic                    r_neg4;
    logic signed [OUTW-1:0]  r_y4;

    // Scale the table step by the fraction.
    assign w_hi   = (r_hi3 < r_lo3) ? r_lo3 : r_hi3;
    assign w_diff = w_hi - r_lo3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod4 <= PRW'(w_diff) * PRW'(r_fr3) + HALF_LSB;
            r_lo4   <= r_lo3;
            r_neg4  <= r_neg3;
            r_y4    <= r_y3;
        end
    end

    // ---------------------------------------------------------------- stage 5
    logic [SAMPLE_BITS-1:0]  w_s;
    logic signed [OUTW-1:0]  w_ss;
    logic signed [OUTW-1:0]  r_out5;

    // Finish interpolation, apply the quadrant sign, pick shaped or plain.
    assign w_s  = r_lo4 + SAMPLE_BITS'(r_prod4 >> KF);
    assign w_ss = $signed(OUTW'(w_s));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_shape_enable) begin
                r_out5 <= r_neg4 ? -w_ss : w_ss;
            end else begin
                r_out5 <= r_y4;
            end
        end
    end

    assign o_smp.valid            = r_v[5];
    assign o_smp.sample_out       = r_out5;
    assign o_smp.end_of_block_out = r_e[5];

    // ---------------------------------------------------------------- checks
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> r_v[1])
        else $error("accepted sample did not enter stage 1");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v) && $stable(r_y3) && $stable(r_prod4)))
        else $error("pipeline moved during an output stall");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_y2 <= $signed(OUTW'(w_c))))
        else $error("clipped sample above clip level");

    a_shape_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_smp.valid && r_shape_enable) |->
        ((o_smp.sample_out <= $signed(OUTW'(64'd1 << FRAC))) &&
         (o_smp.sample_out >= -$signed(OUTW'(64'd1 << FRAC)))))
        else $error("shaped sample outside unit range");

endmodule
